### rtl/mbrtu_pkg.sv
`default_nettype none

package mbrtu_pkg;

   // Request kinds on the input channel
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_BYTE  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   // Result kinds
   localparam logic RESULT_TX   = 1'b0;
   localparam logic RESULT_DONE = 1'b1;

   // Completion status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SHORT   = 2'd1;
   localparam logic [1:0] STATUS_CRC     = 2'd2;
   localparam logic [1:0] STATUS_HEADER  = 2'd3;

   // Modbus function codes and fixed frame fields
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE = 8'h06;
   localparam logic [15:0] READ_COUNT = 16'h0001;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Frame and response sizes
   localparam int FRAME_BYTES                    = 8;
   localparam int MIN_READ_LEN                   = 5;
   localparam int MIN_WRITE_LEN                  = 6;
   localparam int RESPONSE_BUFFER_BYTES_DEFAULT  = 8;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] register_address;
      logic [15:0] write_value;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic        last_of_frame;
      logic [1:0]  status;
      logic [15:0] read_value;
   } rsp_type;

   // Fold one byte into a reflected CRC-16
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/modbus_rtu_master_frame_engine_core.sv
// Modbus RTU master frame engine for single holding registers (FC03 read, FC06 write).
// Input channel req_*: one item is a read request, a write request, a received
// response byte, or an end-of-response / timeout marker.
// Result channel rsp_*: a request yields eight transmit bytes (slave id, function,
// address, count or value, CRC low then high), the eighth flagged last_of_frame.
// An end-of-response marker yields one completion with status and read value.
// Received bytes, and markers with nothing pending, yield no result.
// A completion appears in the cycle after its marker is accepted; for a
// request the frame fields are latched into the sequencer, which then loads the
// bytes into the output register one per cycle unless the receiver stalls.
// Received bytes and markers go at one per cycle while req_ready is high; a
// request holds req_ready low while the frame sequencer walks the eight bytes,
// folding the first six into its CRC register.
// csr_write_enable writes the slave id at once; reset sets it to 1.
// Reset (synchronous) clears the pending transaction, the receive state and
// the output register.
// When the receiver stalls, the output register holds its item and req_ready
// drops until the register is free.
`default_nettype none

module modbus_rtu_master_frame_engine_core #(
   parameter int RESPONSE_BUFFER_BYTES = mbrtu_pkg::RESPONSE_BUFFER_BYTES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire mbrtu_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      mbrtu_pkg::rsp_type rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data
);

   localparam int CNT_W = $clog2(RESPONSE_BUFFER_BYTES + 1);
   localparam int IDX_W = $clog2(mbrtu_pkg::FRAME_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(mbrtu_pkg::FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] IDX_CRC  = IDX_W'(mbrtu_pkg::FRAME_BYTES - 2);

   typedef enum logic [2:0] {
      OP_NONE  = 3'b001,
      OP_READ  = 3'b010,
      OP_WRITE = 3'b100
   } op_type;

   logic [7:0]         slave_ff, slave_in;
   op_type             pending_ff, pending_in;
   logic [CNT_W-1:0]   rx_count_ff, rx_count_in;
   logic [15:0]        rx_crc_ff, rx_crc_in;
   logic [15:0]        rx_last_ff, rx_last_in;
   logic [15:0]        rx_header_ff, rx_header_in;
   logic [15:0]        rx_data_ff, rx_data_in;

   logic               tx_busy_ff, tx_busy_in;
   logic [IDX_W-1:0]   tx_idx_ff, tx_idx_in;
   logic [15:0]        tx_crc_ff, tx_crc_in;
   logic [7:0]         tx_id_ff, tx_id_in;
   logic [7:0]         tx_func_ff, tx_func_in;
   logic [15:0]        tx_addr_ff, tx_addr_in;
   logic [15:0]        tx_word_ff, tx_word_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mbrtu_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               req_fire;
   logic               is_request;
   logic               tx_step;
   logic               done_load;
   logic [7:0]         tx_cur;
   mbrtu_pkg::rsp_type done_item;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !tx_busy_ff && out_free;
   assign req_fire   = req_valid && req_ready;
   assign is_request = (req_data.kind == mbrtu_pkg::KIND_READ) ||
                       (req_data.kind == mbrtu_pkg::KIND_WRITE);
   assign tx_step    = tx_busy_ff && out_free;
   assign done_load  = req_fire && (req_data.kind == mbrtu_pkg::KIND_END) &&
                       (pending_ff != OP_NONE);

   // Pick the frame byte for the current sequencer position
   always_comb begin
      unique case (tx_idx_ff)
         3'd0:    tx_cur = tx_id_ff;
         3'd1:    tx_cur = tx_func_ff;
         3'd2:    tx_cur = tx_addr_ff[15:8];
         3'd3:    tx_cur = tx_addr_ff[7:0];
         3'd4:    tx_cur = tx_word_ff[15:8];
         3'd5:    tx_cur = tx_word_ff[7:0];
         3'd6:    tx_cur = tx_crc_ff[7:0];
         default: tx_cur = tx_crc_ff[15:8];
      endcase
   end

   // Check the collected response and build the completion item
   always_comb begin
      logic             is_read;
      logic [CNT_W-1:0] min_len;
      logic [15:0]      recv_crc;
      is_read  = (pending_ff == OP_READ);
      min_len  = is_read ? CNT_W'(mbrtu_pkg::MIN_READ_LEN) : CNT_W'(mbrtu_pkg::MIN_WRITE_LEN);
      recv_crc = {rx_last_ff[7:0], rx_last_ff[15:8]};
      done_item               = '0;
      done_item.result_kind   = mbrtu_pkg::RESULT_DONE;
      done_item.last_of_frame = 1'b1;
      priority if (rx_count_ff < min_len) begin
         done_item.status = mbrtu_pkg::STATUS_SHORT;
      end else if (rx_crc_ff != recv_crc) begin
         done_item.status = mbrtu_pkg::STATUS_CRC;
      end else if (is_read && (rx_header_ff != {slave_ff, mbrtu_pkg::FUNC_READ})) begin
         done_item.status = mbrtu_pkg::STATUS_HEADER;
      end else begin
         done_item.status = mbrtu_pkg::STATUS_OK;
         if (is_read) begin
            done_item.read_value = rx_data_ff;
         end
      end
   end

   // Next state: configuration, frame sequencer, receive state, output register
   always_comb begin
      slave_in     = slave_ff;
      pending_in   = pending_ff;
      rx_count_in  = rx_count_ff;
      rx_crc_in    = rx_crc_ff;
      rx_last_in   = rx_last_ff;
      rx_header_in = rx_header_ff;
      rx_data_in   = rx_data_ff;
      tx_busy_in   = tx_busy_ff;
      tx_idx_in    = tx_idx_ff;
      tx_crc_in    = tx_crc_ff;
      tx_id_in     = tx_id_ff;
      tx_func_in   = tx_func_ff;
      tx_addr_in   = tx_addr_ff;
      tx_word_in   = tx_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_enable) begin
         slave_in = csr_write_data;
      end

      // Drop a taken item from the output register
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      // Advance the sequencer by one frame byte
      if (tx_step) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.result_kind   = mbrtu_pkg::RESULT_TX;
         rsp_data_in.tx_byte       = tx_cur;
         rsp_data_in.last_of_frame = (tx_idx_ff == IDX_LAST);
         // Fold only the header and data bytes; hold the CRC while it goes out
         if (tx_idx_ff < IDX_CRC) begin
            tx_crc_in = mbrtu_pkg::crc_byte(tx_crc_ff, tx_cur);
         end
         tx_idx_in                 = tx_idx_ff + IDX_W'(1);
         if (tx_idx_ff == IDX_LAST) begin
            tx_busy_in = 1'b0;
         end
      end

      if (req_fire) begin
         if (is_request) begin
            // Latch the frame fields and clear the receive state
            tx_busy_in   = 1'b1;
            tx_idx_in    = '0;
            tx_crc_in    = mbrtu_pkg::CRC_INIT;
            tx_id_in     = slave_ff;
            tx_addr_in   = req_data.register_address;
            if (req_data.kind == mbrtu_pkg::KIND_READ) begin
               tx_func_in = mbrtu_pkg::FUNC_READ;
               tx_word_in = mbrtu_pkg::READ_COUNT;
               pending_in = OP_READ;
            end else begin
               tx_func_in = mbrtu_pkg::FUNC_WRITE;
               tx_word_in = req_data.write_value;
               pending_in = OP_WRITE;
            end
            rx_count_in  = '0;
            rx_crc_in    = mbrtu_pkg::CRC_INIT;
            rx_last_in   = '0;
            rx_header_in = '0;
            rx_data_in   = '0;
         end else if (pending_ff != OP_NONE) begin
            if (req_data.kind == mbrtu_pkg::KIND_BYTE) begin
               // Collect a response byte; the CRC lags two bytes behind
               if (rx_count_ff < CNT_W'(RESPONSE_BUFFER_BYTES)) begin
                  if (rx_count_ff >= CNT_W'(2)) begin
                     rx_crc_in = mbrtu_pkg::crc_byte(rx_crc_ff, rx_last_ff[15:8]);
                  end
                  rx_last_in = {rx_last_ff[7:0], req_data.rx_byte};
                  if (rx_count_ff == CNT_W'(0)) begin
                     rx_header_in = {req_data.rx_byte, 8'h00};
                  end else if (rx_count_ff == CNT_W'(1)) begin
                     rx_header_in = {rx_header_ff[15:8], req_data.rx_byte};
                  end else if (rx_count_ff == CNT_W'(3)) begin
                     rx_data_in = {req_data.rx_byte, 8'h00};
                  end else if (rx_count_ff == CNT_W'(4)) begin
                     rx_data_in = {rx_data_ff[15:8], req_data.rx_byte};
                  end
                  rx_count_in = rx_count_ff + CNT_W'(1);
               end
            end else begin
               // Report the completion and close the transaction
               rsp_valid_in = 1'b1;
               rsp_data_in  = done_item;
               pending_in   = OP_NONE;
            end
         end
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff     <= mbrtu_pkg::SLAVE_ADDRESS_RESET;
         pending_ff   <= OP_NONE;
         rx_count_ff  <= '0;
         rx_crc_ff    <= mbrtu_pkg::CRC_INIT;
         rx_last_ff   <= '0;
         rx_header_ff <= '0;
         rx_data_ff   <= '0;
         tx_busy_ff   <= 1'b0;
         tx_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slave_ff     <= slave_in;
         pending_ff   <= pending_in;
         rx_count_ff  <= rx_count_in;
         rx_crc_ff    <= rx_crc_in;
         rx_last_ff   <= rx_last_in;
         rx_header_ff <= rx_header_in;
         rx_data_ff   <= rx_data_in;
         tx_busy_ff   <= tx_busy_in;
         tx_idx_ff    <= tx_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tx_crc_ff   <= tx_crc_in;
      tx_id_ff    <= tx_id_in;
      tx_func_ff  <= tx_func_in;
      tx_addr_ff  <= tx_addr_in;
      tx_word_ff  <= tx_word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A request arms the sequencer with the slave id as its first frame byte
   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_request) |=> (tx_busy_ff && (tx_idx_ff == '0) &&
         (tx_id_ff == $past(slave_ff))))
      else $error("first frame byte is not the slave id");

   // The sequencer goes idle only after loading the last frame byte
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(tx_busy_ff)) |-> (rsp_valid_ff && rsp_data_ff.last_of_frame &&
         rsp_data_ff.result_kind == mbrtu_pkg::RESULT_TX))
      else $error("frame ended without last byte");

   // A completion closes the pending transaction
   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      done_load |=> (pending_ff == OP_NONE && rsp_valid_ff &&
         rsp_data_ff.result_kind == mbrtu_pkg::RESULT_DONE))
      else $error("completion left a transaction pending");

   // The receive count never passes the buffer size
   a_rx_bound: assert property (@(posedge clock) disable iff (reset)
      (rx_count_ff <= CNT_W'(RESPONSE_BUFFER_BYTES)))
      else $error("receive count overflow");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int          RX_LIMIT       = mbrtu_pkg::RESPONSE_BUFFER_BYTES_DEFAULT;
   localparam int unsigned QUIET_LIMIT    = 2000;
   localparam int unsigned SQUEEZE_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned PHASE_ITEMS    = 70;

   typedef enum logic [1:0] {TXN_IDLE, TXN_READ, TXN_WRITE} txn_type;

   typedef enum int unsigned {
      FAULT_NONE, FAULT_ID, FAULT_FUNC, FAULT_CRC, FAULT_SHORT,
      FAULT_EXCESS, FAULT_JUNK, FAULT_NO_END
   } fault_type;

   // Mirror of the master: builds request frames, tracks the response and
   // queues the transmit bytes and completions that the block owes.
   class modbus_exchange_tracker;
      logic [7:0]         slave_id;
      txn_type            open_txn;
      int unsigned        rx_count;
      logic [15:0]        rx_crc;
      logic [15:0]        rx_tail;
      logic [15:0]        rx_header;
      logic [15:0]        rx_data;
      mbrtu_pkg::rsp_type outbound_due[$];
      int unsigned        mismatches;

      function new();
         slave_id   = mbrtu_pkg::SLAVE_ADDRESS_RESET;
         open_txn   = TXN_IDLE;
         mismatches = 0;
         clear_rx();
      endfunction

      function void clear_rx();
         rx_count  = 0;
         rx_crc    = mbrtu_pkg::CRC_INIT;
         rx_tail   = '0;
         rx_header = '0;
         rx_data   = '0;
      endfunction

      // Reflected CRC-16, one byte at a time
      function logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] data);
         logic [15:0] acc;
         acc = {crc[15:8], crc[7:0] ^ data};
         repeat (8) acc = acc[0] ? ({1'b0, acc[15:1]} ^ mbrtu_pkg::CRC_POLY)
                                 : {1'b0, acc[15:1]};
         return acc;
      endfunction

      function int unsigned due_count();
         return outbound_due.size();
      endfunction

      function void note_item(input mbrtu_pkg::req_type item);
         logic [7:0]         frame [mbrtu_pkg::FRAME_BYTES];
         logic [15:0]        crc;
         logic [15:0]        word;
         logic               is_read;
         mbrtu_pkg::rsp_type entry;
         int                 i;
         unique case (item.kind)
            mbrtu_pkg::KIND_READ, mbrtu_pkg::KIND_WRITE: begin
               is_read  = (item.kind == mbrtu_pkg::KIND_READ);
               word     = is_read ? mbrtu_pkg::READ_COUNT : item.write_value;
               frame[0] = slave_id;
               frame[1] = is_read ? mbrtu_pkg::FUNC_READ : mbrtu_pkg::FUNC_WRITE;
               frame[2] = item.register_address[15:8];
               frame[3] = item.register_address[7:0];
               frame[4] = word[15:8];
               frame[5] = word[7:0];
               crc = mbrtu_pkg::CRC_INIT;
               for (i = 0; i < mbrtu_pkg::FRAME_BYTES - 2; i++) crc = fold_crc(crc, frame[i]);
               frame[6] = crc[7:0];
               frame[7] = crc[15:8];
               for (i = 0; i < mbrtu_pkg::FRAME_BYTES; i++) begin
                  entry               = '0;
                  entry.result_kind   = mbrtu_pkg::RESULT_TX;
                  entry.tx_byte       = frame[i];
                  entry.last_of_frame = (i == mbrtu_pkg::FRAME_BYTES - 1);
                  outbound_due.push_back(entry);
               end
               // a new request drops whatever was open
               open_txn = is_read ? TXN_READ : TXN_WRITE;
               clear_rx();
            end
            mbrtu_pkg::KIND_BYTE: begin
               // keep the CRC two bytes behind, so it never covers the trailer
               if (open_txn != TXN_IDLE && rx_count < RX_LIMIT) begin
                  if (rx_count >= 2) rx_crc = fold_crc(rx_crc, rx_tail[15:8]);
                  rx_tail = {rx_tail[7:0], item.rx_byte};
                  unique case (rx_count)
                     0: rx_header[15:8] = item.rx_byte;
                     1: rx_header[7:0]  = item.rx_byte;
                     3: rx_data[15:8]   = item.rx_byte;
                     4: rx_data[7:0]    = item.rx_byte;
                     default: ;
                  endcase
                  rx_count++;
               end
            end
            mbrtu_pkg::KIND_END: begin
               if (open_txn != TXN_IDLE) begin
                  is_read             = (open_txn == TXN_READ);
                  entry               = '0;
                  entry.result_kind   = mbrtu_pkg::RESULT_DONE;
                  entry.last_of_frame = 1'b1;
                  if (rx_count < (is_read ? mbrtu_pkg::MIN_READ_LEN
                                          : mbrtu_pkg::MIN_WRITE_LEN)) begin
                     entry.status = mbrtu_pkg::STATUS_SHORT;
                  end else if (rx_crc != {rx_tail[7:0], rx_tail[15:8]}) begin
                     entry.status = mbrtu_pkg::STATUS_CRC;
                  end else if (is_read && rx_header != {slave_id, mbrtu_pkg::FUNC_READ}) begin
                     entry.status = mbrtu_pkg::STATUS_HEADER;
                  end else begin
                     entry.status = mbrtu_pkg::STATUS_OK;
                     if (is_read) entry.read_value = rx_data;
                  end
                  outbound_due.push_back(entry);
                  open_txn = TXN_IDLE;
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task compare_field(input string field, input logic [15:0] got, input logic [15:0] want);
         if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
      endtask

      task check_item(input mbrtu_pkg::rsp_type got);
         mbrtu_pkg::rsp_type want;
         if (outbound_due.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing due", got));
         end else begin
            want = outbound_due.pop_front();
            compare_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
            compare_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
            compare_field("last_of_frame", 16'(got.last_of_frame), 16'(want.last_of_frame));
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("read_value", got.read_value, want.read_value);
         end
      endtask
   endclass

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   mbrtu_pkg::req_type req_data         = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   mbrtu_pkg::rsp_type rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [7:0]         csr_write_data   = '0;

   logic        calm         = 1'b0;
   int unsigned squeeze_asks = 0;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;

   modbus_exchange_tracker tracker = new();

   modbus_rtu_master_frame_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic fault_type pick_fault();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return FAULT_NONE;
      if (roll < 58) return FAULT_ID;
      if (roll < 64) return FAULT_FUNC;
      if (roll < 72) return FAULT_CRC;
      if (roll < 81) return FAULT_SHORT;
      if (roll < 88) return FAULT_EXCESS;
      if (roll < 94) return FAULT_JUNK;
      return FAULT_NO_END;
   endfunction

   function automatic mbrtu_pkg::req_type make_item(input logic [1:0] kind,
                                                    input logic [15:0] target_addr,
                                                    input logic [15:0] value,
                                                    input logic [7:0] rx);
      mbrtu_pkg::req_type item;
      item.kind             = kind;
      item.register_address = target_addr;
      item.write_value      = value;
      item.rx_byte          = rx;
      return item;
   endfunction

   // Note accepted items and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_item(req_data);
         if (rsp_valid && rsp_ready) tracker.check_item(rsp_data);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin : rsp_pacing
      int unsigned hold;
      int unsigned squeeze_seen;
      hold         = 0;
      squeeze_seen = 0;
      forever begin
         @(posedge clock);
         if (squeeze_asks != squeeze_seen) begin
            squeeze_seen = squeeze_asks;
            hold         = SQUEEZE_CYCLES;
         end else if (hold == 0) begin
            hold = pick_gap();
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one item, hold it until taken, then maybe idle
   task automatic offer(input mbrtu_pkg::req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_slave_id(input logic [7:0] id);
      csr_write_enable <= 1'b1;
      csr_write_data   <= id;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.slave_id = id;
   endtask

   // One request, then a response shaped by the fault, then end of response
   task automatic run_exchange(input logic is_read, input logic [15:0] target_addr,
                               input logic [15:0] value, input fault_type fault);
      logic [7:0]  reply[$];
      logic [47:0] body;
      logic [15:0] crc;
      logic [7:0]  flip;
      int unsigned n;
      int unsigned idx;
      int unsigned i;
      n    = is_read ? 5 : 6;
      body = is_read ? {tracker.slave_id, mbrtu_pkg::FUNC_READ, 8'h02, value, 8'h00}
                     : {tracker.slave_id, mbrtu_pkg::FUNC_WRITE, target_addr, value};
      flip = 8'($urandom_range(1, 255));
      offer(make_item(is_read ? mbrtu_pkg::KIND_READ : mbrtu_pkg::KIND_WRITE, target_addr,
                      value, 8'($urandom_range(0, 255))));
      for (i = 0; i < n; i++) reply.push_back(body[47 - 8 * i -: 8]);
      if (fault == FAULT_ID) reply[0] = reply[0] ^ flip;
      if (fault == FAULT_FUNC) reply[1] = reply[1] ^ flip;
      // seal the body, low CRC byte first
      crc = mbrtu_pkg::CRC_INIT;
      foreach (reply[j]) crc = tracker.fold_crc(crc, reply[j]);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);
      unique case (fault)
         FAULT_CRC: begin
            idx        = $urandom_range(0, reply.size() - 1);
            reply[idx] = reply[idx] ^ flip;
         end
         FAULT_SHORT: begin
            n = $urandom_range(0, reply.size() - 1);
            while (reply.size() > n) void'(reply.pop_back());
         end
         FAULT_EXCESS: begin
            repeat ($urandom_range(1, 4)) reply.push_back(8'($urandom_range(0, 255)));
         end
         FAULT_JUNK: begin
            reply.delete();
            repeat ($urandom_range(0, 10)) reply.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      foreach (reply[j]) begin
         offer(make_item(mbrtu_pkg::KIND_BYTE, 16'($urandom), 16'($urandom), reply[j]));
      end
      if (fault != FAULT_NO_END) begin
         offer(make_item(mbrtu_pkg::KIND_END, 16'($urandom), 16'($urandom),
                         8'($urandom_range(0, 255))));
      end
   endtask

   initial begin : stimulus
      logic [7:0]  id;
      int unsigned target;
      int          phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle drops, request over an open one, write echo with a bad id,
      // end with nothing open, read with bytes past the buffer
      offer(make_item(mbrtu_pkg::KIND_BYTE, 16'h0000, 16'h0000, 8'hAA));
      offer(make_item(mbrtu_pkg::KIND_END, 16'hFFFF, 16'hFFFF, 8'hFF));
      offer(make_item(mbrtu_pkg::KIND_READ, 16'hFFFF, 16'h0000, 8'h00));
      run_exchange(1'b0, 16'h0000, 16'hFFFF, FAULT_ID);
      offer(make_item(mbrtu_pkg::KIND_END, 16'h0000, 16'h0000, 8'h00));
      run_exchange(1'b1, 16'h8001, 16'hFFFF, FAULT_EXCESS);
      settle();

      // Random phases, each under its own slave id
      for (phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0: id = 8'hFF;
            1: id = 8'h00;
            2: id = mbrtu_pkg::SLAVE_ADDRESS_RESET;
            default: id = 8'($urandom_range(0, 255));
         endcase
         set_slave_id(id);
         calm = (phase == 1);
         if (phase == 3) squeeze_asks++;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            run_exchange(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), pick_fault());
            if ($urandom_range(0, 15) == 0) begin
               offer(make_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                               8'($urandom_range(0, 255))));
            end
         end
         settle();
      end

      if (tracker.mismatches == 0 && tracker.due_count() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
